// ===== design/binary_diff_run_encoder_crc64_core_macros.svh =====
// Assertion macros used by the checker file of the diff-run encoder.
`ifndef BINARY_DIFF_RUN_ENCODER_CRC64_CORE_MACROS_SVH
`define BINARY_DIFF_RUN_ENCODER_CRC64_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define BDRC64_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bdrc64 check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define BDRC64_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bdrc64 check failed");

`endif

// ===== design/bdrc64_pkg.sv =====
// ----------------------------------------------------------------------------
// bdrc64_pkg
// Types, constants and the CRC-64/WE byte step of the diff-run encoder.
// ----------------------------------------------------------------------------
package bdrc64_pkg;

  // Width of the position and length counters
  localparam int unsigned PosWidth = 32;

  localparam logic [63:0] CrcPoly = 64'h42F0_E1EB_A9EA_3693;
  localparam logic [63:0] CrcInit = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int unsigned CrcShift = 56;

  typedef logic [PosWidth-1:0] pos_t;
  typedef logic [63:0] crc_t;

  typedef enum logic [1:0] {
    KIND_CHANGED = 2'd0,
    KIND_CLOSED  = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] orig_byte;
    logic [7:0] mod_byte;
    logic       orig_present;
    logic       last_pair;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic       run_start;
    pos_t       position;
    logic [7:0] new_byte;
    crc_t       orig_crc;
    crc_t       mod_crc;
    pos_t       orig_length;
    pos_t       total_length;
    logic       last_out;
  } out_item_t;

  // One byte of CRC-64/WE, MSB first: eight XOR-only shift steps
  function automatic crc_t crc64_byte(crc_t crc, logic [7:0] data);
    crc_t c;
    c = crc ^ ({56'd0, data} << CrcShift);
    for (int k = 0; k < 8; k++) begin
      if (c[63]) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  // Increment that holds at the counter maximum
  function automatic pos_t sat_inc(pos_t v);
    pos_t r;
    r = (v == '1) ? v : v + pos_t'(1);
    return r;
  endfunction

endpackage

// ===== design/bdrc64_in_if.sv =====
// ----------------------------------------------------------------------------
// bdrc64_in_if
// Valid/ready channel carrying one byte pair per transaction.
// ----------------------------------------------------------------------------
interface bdrc64_in_if;
  logic                 valid;
  logic                 ready;
  bdrc64_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/bdrc64_out_if.sv =====
// ----------------------------------------------------------------------------
// bdrc64_out_if
// Valid/ready channel carrying one result item per transaction.
// ----------------------------------------------------------------------------
interface bdrc64_out_if;
  logic                  valid;
  logic                  ready;
  bdrc64_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/binary_diff_run_encoder_crc64_core.sv =====
// ----------------------------------------------------------------------------
// binary_diff_run_encoder_crc64_core
// Byte-pair diff encoder with CRC-64/WE of both images and run tracking.
// ----------------------------------------------------------------------------
//
//  channel | dir | transaction
//  --------+-----+-------------------------------------------------
//  in_i    | in  | one aligned byte pair (orig, mod, present, last)
//  out_o   | out | changed byte, run closed or end summary
//
//  A pair is taken every cycle while the result queue has two free slots.
//  A pair makes zero, one or two results; the queue drains one per cycle
//  while out_o is ready, so pairs that each make two results fill the queue and stall in_i.
//  Reset (rst_ni low) clears both CRCs to all ones, the counters, the run
//  flag and the queue; the last pair returns the state to those values.
//  A stalled output holds its item; new pairs still enter while two slots are free.
module binary_diff_run_encoder_crc64_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  bdrc64_in_if.sink    in_i,
  bdrc64_out_if.source out_o
);

  localparam int unsigned QDepth = 4;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned CntW   = $clog2(QDepth + 1);

  // State
  bdrc64_pkg::crc_t orig_crc_q, orig_crc_d;
  bdrc64_pkg::crc_t mod_crc_q, mod_crc_d;
  bdrc64_pkg::pos_t pos_q, pos_d;
  bdrc64_pkg::pos_t orig_cnt_q, orig_cnt_d;
  logic             run_open_q, run_open_d;

  // Result queue
  bdrc64_pkg::out_item_t queue_q [QDepth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;

  logic                  in_fire, out_fire;
  logic                  differs, has_first;
  logic [1:0]            wr_num;
  bdrc64_pkg::crc_t      orig_crc_nx, mod_crc_nx;
  bdrc64_pkg::pos_t      pos_nx, orig_cnt_nx;
  bdrc64_pkg::out_item_t run_item, sum_item, item_a, item_b;

  // Accept while two slots are free
  assign in_i.ready    = (count_q <= CntW'(QDepth - 2));
  assign in_fire       = in_i.valid && in_i.ready;
  assign out_o.valid   = (count_q != '0);
  assign out_o.payload = queue_q[rd_ptr_q];
  assign out_fire      = out_o.valid && out_o.ready;

  // Advance checksums and counters for this pair
  always_comb begin
    orig_crc_nx = bdrc64_pkg::crc64_byte(orig_crc_q, in_i.payload.orig_byte);
    mod_crc_nx  = bdrc64_pkg::crc64_byte(mod_crc_q, in_i.payload.mod_byte);
    pos_nx      = bdrc64_pkg::sat_inc(pos_q);
    orig_cnt_nx = in_i.payload.orig_present ? bdrc64_pkg::sat_inc(orig_cnt_q)
                                            : orig_cnt_q;
    differs     = (in_i.payload.orig_byte != in_i.payload.mod_byte);
    has_first   = differs || run_open_q;
  end

  // Build the changed/closed item and the summary item
  always_comb begin
    run_item           = '0;
    run_item.kind      = differs ? bdrc64_pkg::KIND_CHANGED : bdrc64_pkg::KIND_CLOSED;
    run_item.run_start = differs && !run_open_q;
    run_item.position  = differs ? pos_q : '0;
    run_item.new_byte  = differs ? in_i.payload.mod_byte : 8'd0;
    run_item.last_out  = !in_i.payload.last_pair;

    sum_item              = '0;
    sum_item.kind         = bdrc64_pkg::KIND_SUMMARY;
    sum_item.orig_crc     = ~orig_crc_nx;
    sum_item.mod_crc      = ~mod_crc_nx;
    sum_item.orig_length  = orig_cnt_nx;
    sum_item.total_length = pos_nx;
    sum_item.last_out     = 1'b1;

    item_a = has_first ? run_item : sum_item;
    item_b = sum_item;
    wr_num = {1'b0, has_first} + {1'b0, in_i.payload.last_pair};
  end

  // Next state: the last pair restarts the images
  always_comb begin
    orig_crc_d = orig_crc_q;
    mod_crc_d  = mod_crc_q;
    pos_d      = pos_q;
    orig_cnt_d = orig_cnt_q;
    run_open_d = run_open_q;
    if (in_fire) begin
      if (in_i.payload.last_pair) begin
        orig_crc_d = bdrc64_pkg::CrcInit;
        mod_crc_d  = bdrc64_pkg::CrcInit;
        pos_d      = '0;
        orig_cnt_d = '0;
        run_open_d = 1'b0;
      end else begin
        orig_crc_d = orig_crc_nx;
        mod_crc_d  = mod_crc_nx;
        pos_d      = pos_nx;
        orig_cnt_d = orig_cnt_nx;
        run_open_d = differs;
      end
    end
  end

  // Queue pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (in_fire) begin
      wr_ptr_d = wr_ptr_q + PtrW'(wr_num);
      count_d  = count_d + CntW'(wr_num);
    end
    if (out_fire) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
      count_d  = count_d - CntW'(1);
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orig_crc_q <= bdrc64_pkg::CrcInit;
      mod_crc_q  <= bdrc64_pkg::CrcInit;
      pos_q      <= '0;
      orig_cnt_q <= '0;
      run_open_q <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      count_q    <= '0;
    end else begin
      orig_crc_q <= orig_crc_d;
      mod_crc_q  <= mod_crc_d;
      pos_q      <= pos_d;
      orig_cnt_q <= orig_cnt_d;
      run_open_q <= run_open_d;
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      count_q    <= count_d;
    end
  end

  // Write up to two results into the queue
  always_ff @(posedge clk_i) begin
    if (in_fire && (wr_num != 2'd0)) begin
      queue_q[wr_ptr_q] <= item_a;
    end
    if (in_fire && (wr_num == 2'd2)) begin
      queue_q[wr_ptr_q + PtrW'(1)] <= item_b;
    end
  end

endmodule

// ===== design/bdrc64_checker.sv =====
// ----------------------------------------------------------------------------
// bdrc64_checker
// Port-level checks of the diff-run encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "binary_diff_run_encoder_crc64_core_macros.svh"

module bdrc64_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input bdrc64_pkg::in_item_t  in_payload_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input bdrc64_pkg::out_item_t out_payload_i
);

  logic in_fire, out_fire;
  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  // A stalled result stays offered and unchanged
  `BDRC64_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_payload_i))

  // A summary always ends the results of its pair
  `BDRC64_ASSERT_NOW(a_sum_last, out_valid_i && (out_payload_i.kind == bdrc64_pkg::KIND_SUMMARY), out_payload_i.last_out)

  // A result that is not the last of its pair is followed at once by the summary
  `BDRC64_ASSERT_NEXT(a_pair_follow, out_fire && !out_payload_i.last_out, out_valid_i && (out_payload_i.kind == bdrc64_pkg::KIND_SUMMARY))

  // A last pair always leaves a result waiting
  `BDRC64_ASSERT_NEXT(a_last_result, in_fire && in_payload_i.last_pair, out_valid_i)

endmodule

bind binary_diff_run_encoder_crc64_core bdrc64_checker u_bdrc64_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_payload_i  (in_i.payload),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);

// ===== tb/binary_diff_run_encoder_crc64_core_tb.sv =====
// ----------------------------------------------------------------------------
// binary_diff_run_encoder_crc64_core_tb
// Self-checking bench for the byte-pair diff encoder. A scoreboard class
// tracks both CRC-64/WE streams, the counters and the run flag, and queues
// the items that each accepted pair must produce. Directed images cover run
// open, continue and close, padding on either side, and runs still open at
// the last pair. Random well-formed images and some noise pairs follow,
// under bursty input, a patterned output stall and one long output hold-off.
// ----------------------------------------------------------------------------
package bdrc64_tb_pkg;

  class diff_run_scoreboard;
    bdrc64_pkg::crc_t      orig_crc;
    bdrc64_pkg::crc_t      mod_crc;
    bdrc64_pkg::pos_t      pos_count;
    bdrc64_pkg::pos_t      orig_count;
    bit                    run_open;
    bdrc64_pkg::out_item_t expected_results[$];
    int unsigned           error_count;
    int unsigned           result_count;

    function new();
      error_count  = 0;
      result_count = 0;
      restart();
    endfunction

    // Return the tracked image state to its reset values
    function void restart();
      orig_crc   = bdrc64_pkg::CrcInit;
      mod_crc    = bdrc64_pkg::CrcInit;
      pos_count  = '0;
      orig_count = '0;
      run_open   = 1'b0;
    endfunction

    // Bitwise CRC-64/WE update, data MSB first
    function bdrc64_pkg::crc_t crc_step(bdrc64_pkg::crc_t c, logic [7:0] b);
      bdrc64_pkg::crc_t r;
      logic             fb;
      r = c;
      for (int i = 7; i >= 0; i--) begin
        fb = r[63] ^ b[i];
        r  = {r[62:0], 1'b0};
        if (fb) begin
          r = r ^ bdrc64_pkg::CrcPoly;
        end
      end
      return r;
    endfunction

    // Counter increment that sticks at all ones
    function bdrc64_pkg::pos_t bump(bdrc64_pkg::pos_t v);
      return (&v) ? v : v + 1'b1;
    endfunction

    // Advance the state by one accepted pair and queue what it produces
    function void note_pair(bdrc64_pkg::in_item_t p);
      bdrc64_pkg::pos_t      here;
      bdrc64_pkg::out_item_t made [2];
      int                    n;
      here      = pos_count;
      n         = 0;
      orig_crc  = crc_step(orig_crc, p.orig_byte);
      mod_crc   = crc_step(mod_crc, p.mod_byte);
      pos_count = bump(pos_count);
      if (p.orig_present) begin
        orig_count = bump(orig_count);
      end
      if (p.orig_byte != p.mod_byte) begin
        made[n]           = '0;
        made[n].kind      = bdrc64_pkg::KIND_CHANGED;
        made[n].run_start = !run_open;
        made[n].position  = here;
        made[n].new_byte  = p.mod_byte;
        run_open          = 1'b1;
        n++;
      end else if (run_open) begin
        made[n]      = '0;
        made[n].kind = bdrc64_pkg::KIND_CLOSED;
        run_open     = 1'b0;
        n++;
      end
      if (p.last_pair) begin
        made[n]              = '0;
        made[n].kind         = bdrc64_pkg::KIND_SUMMARY;
        made[n].orig_crc     = ~orig_crc;
        made[n].mod_crc      = ~mod_crc;
        made[n].orig_length  = orig_count;
        made[n].total_length = pos_count;
        n++;
        restart();
      end
      if (n > 0) begin
        made[n-1].last_out = 1'b1;
      end
      for (int k = 0; k < n; k++) begin
        expected_results = {expected_results, made[k]};
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Print one line per mismatch and count it
    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      error_count++;
      $display("mismatch at result %0d, %s: got %h, expected %h",
               result_count, what, got, want);
    endtask

    // Compare one accepted result against the oldest expectation
    task check_result(bdrc64_pkg::out_item_t got);
      bdrc64_pkg::out_item_t want;
      result_count++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, kind", 64'(got.kind), '0);
        return;
      end
      want = expected_results.pop_front();
      if (got.kind !== want.kind) begin
        report_mismatch("kind", 64'(got.kind), 64'(want.kind));
      end
      if (got.run_start !== want.run_start) begin
        report_mismatch("run_start", 64'(got.run_start), 64'(want.run_start));
      end
      if (got.position !== want.position) begin
        report_mismatch("position", 64'(got.position), 64'(want.position));
      end
      if (got.new_byte !== want.new_byte) begin
        report_mismatch("new_byte", 64'(got.new_byte), 64'(want.new_byte));
      end
      if (got.orig_crc !== want.orig_crc) begin
        report_mismatch("orig_crc", got.orig_crc, want.orig_crc);
      end
      if (got.mod_crc !== want.mod_crc) begin
        report_mismatch("mod_crc", got.mod_crc, want.mod_crc);
      end
      if (got.orig_length !== want.orig_length) begin
        report_mismatch("orig_length", 64'(got.orig_length), 64'(want.orig_length));
      end
      if (got.total_length !== want.total_length) begin
        report_mismatch("total_length", 64'(got.total_length), 64'(want.total_length));
      end
      if (got.last_out !== want.last_out) begin
        report_mismatch("last_out", 64'(got.last_out), 64'(want.last_out));
      end
    endtask
  endclass

endpackage

module binary_diff_run_encoder_crc64_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomPairs   = 1800;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned HoldoffCycles = 400;
  localparam int unsigned HoldoffAfter  = 300;
  localparam int unsigned DrainCycles   = 16;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 pair_valid   = 1'b0;
  bdrc64_pkg::in_item_t pair_data    = '0;
  logic                 result_ready = 1'b0;

  bdrc64_in_if  pair_if ();
  bdrc64_out_if result_if ();

  assign pair_if.valid   = pair_valid;
  assign pair_if.payload = pair_data;
  assign result_if.ready = result_ready;

  binary_diff_run_encoder_crc64_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pair_if),
    .out_o  (result_if)
  );

  bdrc64_tb_pkg::diff_run_scoreboard sb = new();

  bdrc64_pkg::in_item_t pair_stream[$];
  int unsigned send_idx     = 0;
  bit          pair_fire    = 1'b0;
  int unsigned burst_left   = 1;
  int unsigned gap_left     = 0;
  int unsigned results_seen = 0;
  int unsigned holdoff_left = 0;
  bit          holdoff_done = 1'b0;
  int unsigned stall_mode   = 0;
  int unsigned mode_left    = 0;
  int unsigned stall_phase  = 0;
  int unsigned idle_cycles  = 0;

  // Free-running clock
  always #6 clk_i = ~clk_i;

  function automatic void push_pair(logic [7:0] ob, logic [7:0] mb, logic pres, logic last);
    bdrc64_pkg::in_item_t p;
    p.orig_byte    = ob;
    p.mod_byte     = mb;
    p.orig_present = pres;
    p.last_pair    = last;
    pair_stream    = {pair_stream, p};
  endfunction

  // One well-formed image pair: shorter side padded with zeros, runs of diffs
  function automatic void add_image(int unsigned orig_len, int unsigned mod_len);
    int unsigned total;
    logic [7:0]  ob;
    logic [7:0]  mb;
    bit          differ;
    total  = (orig_len > mod_len) ? orig_len : mod_len;
    differ = 1'b0;
    for (int unsigned i = 0; i < total; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        differ = !differ;
      end
      ob = (i < orig_len) ? 8'($urandom) : 8'h00;
      if (i >= mod_len) begin
        mb = 8'h00;
      end else if (differ) begin
        mb = ob ^ 8'($urandom_range(1, 255));
      end else begin
        mb = ob;
      end
      push_pair(ob, mb, i < orig_len, i == total - 1);
    end
  endfunction

  // Directed images first, then random images mixed with noise pairs
  task automatic build_stream();
    int unsigned directed;
    int unsigned olen;
    int unsigned mlen;
    int unsigned cap;
    // equal, open, continue, close, equal, diff on last pair
    push_pair(8'h00, 8'h00, 1'b1, 1'b0);
    push_pair(8'hFF, 8'h00, 1'b1, 1'b0);
    push_pair(8'h00, 8'hFF, 1'b1, 1'b0);
    push_pair(8'hFF, 8'hFF, 1'b1, 1'b0);
    push_pair(8'h5A, 8'h5A, 1'b1, 1'b0);
    push_pair(8'hA5, 8'h3C, 1'b1, 1'b1);
    // single-pair images, summary only
    push_pair(8'h00, 8'h00, 1'b1, 1'b1);
    push_pair(8'hFF, 8'hFF, 1'b1, 1'b1);
    // original shorter than modified
    push_pair(8'h12, 8'h12, 1'b1, 1'b0);
    push_pair(8'h34, 8'h35, 1'b1, 1'b0);
    push_pair(8'h00, 8'h56, 1'b0, 1'b0);
    push_pair(8'h00, 8'h00, 1'b0, 1'b0);
    push_pair(8'h00, 8'hFF, 1'b0, 1'b1);
    // modified shorter, run still open at the last pair
    push_pair(8'h11, 8'h11, 1'b1, 1'b0);
    push_pair(8'h22, 8'h22, 1'b1, 1'b0);
    push_pair(8'h33, 8'h00, 1'b1, 1'b0);
    push_pair(8'h44, 8'h00, 1'b1, 1'b1);
    // run closed well before the last pair
    push_pair(8'h80, 8'h7F, 1'b1, 1'b0);
    push_pair(8'h01, 8'h01, 1'b1, 1'b0);
    push_pair(8'h01, 8'h01, 1'b1, 1'b1);
    // equal last pair closing an open run: closed item and summary
    push_pair(8'h00, 8'h01, 1'b1, 1'b0);
    push_pair(8'h02, 8'h02, 1'b1, 1'b1);
    directed = pair_stream.size();

    while (pair_stream.size() < directed + RandomPairs) begin
      if ($urandom_range(0, 99) < 85) begin
        cap  = ($urandom_range(0, 19) == 0) ? 160 : 24;
        olen = $urandom_range(0, cap);
        mlen = ($urandom_range(0, 2) == 0) ? olen : $urandom_range(0, cap);
        if ((olen == 0) && (mlen == 0)) begin
          olen = 1;
        end
        add_image(olen, mlen);
      end else begin
        // noise: fields unrelated to any image layout
        repeat ($urandom_range(1, 8)) begin
          push_pair(8'($urandom), 8'($urandom), 1'($urandom),
                    $urandom_range(0, 15) == 0);
        end
      end
    end
  endtask

  // Note accepted pairs, then check accepted results
  always @(posedge clk_i) begin
    pair_fire = pair_valid && pair_if.ready;
    if (pair_fire) begin
      sb.note_pair(pair_data);
    end
    if (result_if.valid && result_ready) begin
      sb.check_result(result_if.payload);
      results_seen++;
    end
  end

  // Offer pairs in bursts with random gaps; hold a pair until it is taken
  always @(negedge clk_i) begin
    if (pair_fire) begin
      send_idx++;
    end
    if (pair_valid && !pair_fire) begin
      // hold the pending transaction
    end else if (rst_ni && (send_idx < pair_stream.size()) && (gap_left == 0)) begin
      pair_valid <= 1'b1;
      pair_data  <= pair_stream[send_idx];
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 30);
        gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
      end
    end else begin
      pair_valid <= 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end
    end
  end

  // Drive ready: one long hold-off, otherwise a rotating stall pattern
  always @(negedge clk_i) begin
    stall_phase++;
    if (holdoff_left > 0) begin
      holdoff_left--;
      result_ready <= 1'b0;
    end else if (!holdoff_done && (results_seen >= HoldoffAfter)) begin
      holdoff_done = 1'b1;
      holdoff_left = HoldoffCycles;
      result_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(8, 80);
      end
      mode_left--;
      case (stall_mode)
        0: begin
          result_ready <= 1'b1;
        end
        1: begin
          result_ready <= ($urandom_range(0, 3) != 0);
        end
        2: begin
          result_ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          result_ready <= ((stall_phase % 3) == 0);
        end
      endcase
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if ((pair_valid && pair_if.ready) || (result_if.valid && result_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Reset, run the stream, drain and give the verdict
  initial begin
    build_stream();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (!((send_idx == pair_stream.size()) && (sb.pending() == 0))) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.report_mismatch("results never produced", '0, 64'(sb.pending()));
    end
    if (sb.error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
